// File: sv/lrie_pkg.sv
// Shared types, codes and helper functions for the lossless RGB image encoder.
`default_nettype none

package lrie_pkg;

    // Action codes carried by an input beat.
    localparam logic [1:0] ACT_PIXEL = 2'd0;
    localparam logic [1:0] ACT_FLUSH = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    // Coder constants.
    localparam logic [63:0] RANGE_INIT   = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] RENORM_LIMIT = 64'h0000_0000_0000_FFFF;
    localparam logic [31:0] RANGE_FILL   = 32'hFFFF_FFFF;
    localparam logic [32:0] DIV_BASE     = 33'h1_0000_0000;

    // Statistics constants.
    localparam int          CNT_W        = 13;
    localparam int          ENERGY_W     = 13;
    localparam logic [12:0] TOTAL_HALVE  = 13'h1000;
    localparam logic [12:0] TOTAL_FLOOR  = 13'd256;
    localparam logic [16:0] ENERGY_MAX   = 17'd8191;

    // Shared multiplier operand widths.
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [31:0] code_word;
        logic        last_word;
    } out_item_t;

    // Position of the highest set bit of a 27-bit value (zero for zero and one).
    function automatic logic [4:0] floor_log2_27(input logic [26:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 1; i < 27; i++) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/lossless_rgb_image_encoder.sv
// Top level of the lossless RGB image encoder: predictor, context model and range coder.
//
//  channel | ports                          | direction | beat contents
//  --------+--------------------------------+-----------+------------------------------
//  input   | s_valid, s_ready, s_data       | in        | action, red, green, blue
//  result  | m_valid, m_ready, m_data       | out       | code_word, last_word
//  config  | cfg_wr_en, cfg_wr_data         | in        | image_width, no wait
//
// A pixel runs 12 sequencer steps per channel on the shared 40x16 multiplier and on
// tables with one read and one write port; an emit step then hands out each result word.
// A table rebuild adds the divider and scale steps and a read and a write per symbol.
// A flush emits both halves of low. Reset and start clear the tables, stepping over
// max(3*MAX_WIDTH, 3*NUM_CONTEXTS*256) entries (13824 at the defaults) with s_ready low.
// Result words wait in an output register; a stalled m_ready holds the sequencer only
// when a new word must be loaded while the register is still full.
`default_nettype none

module lossless_rgb_image_encoder
    import lrie_pkg::*;
#(
    parameter int MAX_WIDTH    = 4096,
    parameter int NUM_CONTEXTS = 18,
    parameter int PROB_BITS    = 12,
    parameter int ENERGY_SHIFT = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    localparam int NCTX_ALL  = 3 * NUM_CONTEXTS;
    localparam int CX_W      = $clog2(NCTX_ALL);
    localparam int SYM_DEPTH = NCTX_ALL * 256;
    localparam int SYM_AW    = CX_W + 8;
    localparam int LV_DEPTH  = 3 * MAX_WIDTH;
    localparam int LV_AW     = $clog2(LV_DEPTH);
    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int CLR_DEPTH = (LV_DEPTH > SYM_DEPTH) ? LV_DEPTH : SYM_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam int UNI_SHIFT = PROB_BITS - 8;
    localparam logic [PROB_BITS:0] PROB_ONE = (PROB_BITS + 1)'(1 << PROB_BITS);
    localparam logic [MUL_B_W-1:0] SCALE_MUL = MUL_B_W'((1 << PROB_BITS) - 256);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_PRED, ST_CUM0, ST_CUM1, ST_CUM2,
        ST_LO_L, ST_LO_H, ST_LO_S, ST_SP_L, ST_SP_H, ST_SP_S, ST_FIN,
        ST_DIV, ST_SCALE, ST_SCALE_L, ST_RB_RD, ST_RB_WR, ST_EMIT
    } state_t;

    // Control and coder registers.
    state_t                state_reg, state_next;
    logic [CLR_AW-1:0]     clr_reg, clr_next;
    logic [12:0]           width_reg, width_next;
    logic [1:0]            chan_reg, chan_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [WW-1:0]         weff_reg, weff_next;
    logic [7:0]            red_reg, red_next;
    logic [7:0]            green_reg, green_next;
    logic [7:0]            blue_reg, blue_next;
    logic signed [8:0]     w_reg [3];
    logic signed [8:0]     w_next [3];
    logic [ENERGY_W-1:0]   ew_reg [3];
    logic [ENERGY_W-1:0]   ew_next [3];
    logic signed [8:0]     nw_reg [3];
    logic signed [8:0]     nw_next [3];
    logic [63:0]           low_reg, low_next;
    logic [63:0]           range_reg, range_next;
    logic [31:0]           wbuf_reg [3];
    logic [31:0]           wbuf_next [3];
    logic [1:0]            wcnt_reg, wcnt_next;
    logic [1:0]            widx_reg, widx_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;
    logic [7:0]            sym_reg, sym_next;
    logic [CX_W-1:0]       cx_reg, cx_next;
    logic [PROB_BITS-1:0]  cum_lo_reg, cum_lo_next;
    logic [PROB_BITS:0]    span_reg, span_next;
    logic [47:0]           p0_reg, p0_next;
    logic [63:0]           sum_reg, sum_next;
    logic [MUL_P_W-1:0]    mul_p_reg, mul_p_next;
    logic                  rb_need_reg, rb_need_next;
    logic                  rb_halve_reg, rb_halve_next;
    logic                  rb_extra_reg, rb_extra_next;
    logic [12:0]           rb_tot_reg, rb_tot_next;
    logic [32:0]           dvd_reg, dvd_next;
    logic [12:0]           rem_reg, rem_next;
    logic [5:0]            dcnt_reg, dcnt_next;
    logic [MUL_A_W-1:0]    scale_reg, scale_next;
    logic [7:0]            rb_s_reg, rb_s_next;
    logic [13:0]           acc_reg, acc_next;
    logic [12:0]           rb_sum_reg, rb_sum_next;

    // Table ports.
    logic                  lv_we, le_we, cnt_we, cum_we, tot_we;
    logic [LV_AW-1:0]      lv_wa, lv_ra, le_wa, le_ra;
    logic signed [8:0]     lv_wd, lv_rd;
    logic [ENERGY_W-1:0]   le_wd, le_rd;
    logic [SYM_AW-1:0]     cnt_wa, cnt_ra, cum_wa, cum_ra;
    logic [CNT_W-1:0]      cnt_wd, cnt_rd;
    logic [PROB_BITS-1:0]  cum_wd, cum_rd;
    logic [CX_W-1:0]       tot_wa, tot_ra;
    logic [12:0]           tot_wd, tot_rd;

    logic signed [8:0]     lv_mem [LV_DEPTH];
    logic [ENERGY_W-1:0]   le_mem [LV_DEPTH];
    logic [CNT_W-1:0]      cnt_mem [SYM_DEPTH];
    logic [PROB_BITS-1:0]  cum_mem [SYM_DEPTH];
    logic [12:0]           tot_mem [NCTX_ALL];

    // Shared multiplier operands.
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sequencer and datapath next-state logic.
    always_comb begin
        int                  base;
        int                  ctx;
        int                  width_i;
        int                  col_i;
        logic                ene_ok;
        logic [7:0]          samp8;
        logic [7:0]          bias8;
        logic signed [10:0]  up_e, west_e, nw_e, g_raw, g_lo, g_hi, g_cl, g_b;
        logic [7:0]          pred8;
        logic signed [9:0]   diff_s;
        logic [9:0]          mag;
        logic [9:0]          zz;
        logic [16:0]         en_sum;
        logic [ENERGY_W-1:0] en;
        logic signed [8:0]   vs;
        logic [4:0]          lg;
        logic [12:0]         tplus;
        logic [PROB_BITS:0]  hi_v;
        logic [63:0]         nl;
        logic [63:0]         nr;
        logic [13:0]         rem_sh;
        logic                adv;
        logic [CNT_W-1:0]    half;

        state_next    = state_reg;
        clr_next      = clr_reg;
        width_next    = width_reg;
        chan_next     = chan_reg;
        col_next      = col_reg;
        weff_next     = weff_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        blue_next     = blue_reg;
        w_next        = w_reg;
        ew_next       = ew_reg;
        nw_next       = nw_reg;
        low_next      = low_reg;
        range_next    = range_reg;
        wbuf_next     = wbuf_reg;
        wcnt_next     = wcnt_reg;
        widx_next     = widx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        sym_next      = sym_reg;
        cx_next       = cx_reg;
        cum_lo_next   = cum_lo_reg;
        span_next     = span_reg;
        p0_next       = p0_reg;
        sum_next      = sum_reg;
        rb_need_next  = rb_need_reg;
        rb_halve_next = rb_halve_reg;
        rb_extra_next = rb_extra_reg;
        rb_tot_next   = rb_tot_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        scale_next    = scale_reg;
        rb_s_next     = rb_s_reg;
        acc_next      = acc_reg;
        rb_sum_next   = rb_sum_reg;

        lv_we = 1'b0;  lv_wa = '0;  lv_wd = '0;  lv_ra = '0;
        le_we = 1'b0;  le_wa = '0;  le_wd = '0;  le_ra = '0;
        cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = '0;
        cum_we = 1'b0; cum_wa = '0; cum_wd = '0; cum_ra = '0;
        tot_we = 1'b0; tot_wa = '0; tot_wd = '0; tot_ra = '0;
        mul_a = '0;
        mul_b = '0;
        adv   = 1'b0;

        if (cfg_wr_en) begin
            width_next = cfg_wr_data;
        end

        // Per-channel operands.
        base    = int'(chan_reg) * MAX_WIDTH;
        col_i   = int'(col_reg);
        width_i = int'(weff_reg);
        ene_ok  = (col_i + 3 < width_i);
        case (chan_reg)
            2'd0:    samp8 = green_reg;
            2'd1:    samp8 = red_reg;
            default: samp8 = blue_reg;
        endcase
        bias8 = (chan_reg == 2'd0) ? 8'd0 : green_reg;

        // Clamped gradient prediction and residual.
        up_e   = $signed({{2{lv_rd[8]}}, lv_rd});
        west_e = $signed({{2{w_reg[chan_reg][8]}}, w_reg[chan_reg]});
        nw_e   = $signed({{2{nw_reg[chan_reg][8]}}, nw_reg[chan_reg]});
        g_raw  = up_e + west_e - nw_e;
        g_lo   = (up_e < west_e) ? up_e : west_e;
        g_hi   = (up_e < west_e) ? west_e : up_e;
        g_cl   = (g_raw < g_lo) ? g_lo : ((g_raw > g_hi) ? g_hi : g_raw);
        g_b    = g_cl + $signed({3'b000, bias8});
        if (g_b < 11'sd0) begin
            pred8 = 8'd0;
        end else if (g_b > 11'sd255) begin
            pred8 = 8'd255;
        end else begin
            pred8 = g_b[7:0];
        end
        diff_s = $signed({2'b00, samp8}) - $signed({2'b00, pred8});
        mag    = diff_s[9] ? 10'(-diff_s) : 10'(diff_s);
        zz     = diff_s[9] ? ({mag[8:0], 1'b0} - 10'd1) : {mag[8:0], 1'b0};
        vs     = $signed({1'b0, samp8}) - $signed({1'b0, bias8});

        // Energy update with saturation.
        en_sum = {3'b000, ew_reg[chan_reg], 1'b0} + (17'(zz) << ENERGY_SHIFT)
                 + (ene_ok ? 17'(le_rd) : 17'd0);
        en_sum = en_sum >> 2;
        en     = (en_sum > ENERGY_MAX) ? ENERGY_MAX[ENERGY_W-1:0] : en_sum[ENERGY_W-1:0];

        // Context from the squared west energy held in the multiplier register.
        lg  = floor_log2_27(27'(mul_p_reg[25:0]) + 27'd1);
        ctx = (int'(lg) > NUM_CONTEXTS - 1) ? NUM_CONTEXTS - 1 : int'(lg);
        ctx = ctx + NUM_CONTEXTS * int'(chan_reg);

        tplus  = tot_rd + 13'd1;
        hi_v   = (sym_reg == 8'd255) ? PROB_ONE : {1'b0, cum_rd};
        nl     = {low_reg[31:0], 32'd0};
        nr     = {range_reg[31:0], RANGE_FILL};
        rem_sh = {rem_reg, dvd_reg[32]};
        half   = cnt_rd >> 1;

        case (state_reg)
            // Clearing pass over all tables.
            ST_CLEAR: begin
                lv_we  = (32'(clr_reg) < LV_DEPTH);
                lv_wa  = clr_reg[LV_AW-1:0];
                le_we  = lv_we;
                le_wa  = clr_reg[LV_AW-1:0];
                cnt_we = (32'(clr_reg) < SYM_DEPTH);
                cnt_wa = clr_reg[SYM_AW-1:0];
                cum_we = cnt_we;
                cum_wa = clr_reg[SYM_AW-1:0];
                cum_wd = PROB_BITS'(clr_reg[7:0]) << UNI_SHIFT;
                tot_we = (32'(clr_reg) < NCTX_ALL);
                tot_wa = clr_reg[CX_W-1:0];
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == CLR_DEPTH - 1) begin
                    state_next = ST_IDLE;
                end
            end

            // Take one input beat.
            ST_IDLE: begin
                if (s_valid) begin
                    red_next   = s_data.red;
                    green_next = s_data.green;
                    blue_next  = s_data.blue;
                    case (s_data.action)
                        ACT_PIXEL: begin
                            if (width_reg == 13'd0) begin
                                weff_next = WW'(1);
                            end else if (32'(width_reg) > MAX_WIDTH) begin
                                weff_next = WW'(MAX_WIDTH);
                            end else begin
                                weff_next = WW'(width_reg);
                            end
                            if (32'(col_reg) >= 32'(weff_next)) begin
                                col_next = '0;
                                for (int i = 0; i < 3; i++) begin
                                    w_next[i]  = '0;
                                    ew_next[i] = '0;
                                    nw_next[i] = '0;
                                end
                            end
                            chan_next  = 2'd0;
                            wcnt_next  = 2'd0;
                            widx_next  = 2'd0;
                            state_next = ST_RD;
                        end
                        ACT_FLUSH: begin
                            wbuf_next[0] = low_reg[63:32];
                            wbuf_next[1] = low_reg[31:0];
                            wcnt_next    = 2'd2;
                            widx_next    = 2'd0;
                            low_next     = '0;
                            range_next   = RANGE_INIT;
                            state_next   = ST_EMIT;
                        end
                        ACT_START: begin
                            clr_next   = '0;
                            low_next   = '0;
                            range_next = RANGE_INIT;
                            col_next   = '0;
                            for (int i = 0; i < 3; i++) begin
                                w_next[i]  = '0;
                                ew_next[i] = '0;
                                nw_next[i] = '0;
                            end
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Read the row above and square the west energy.
            ST_RD: begin
                lv_ra = LV_AW'(base + col_i);
                le_ra = ene_ok ? LV_AW'(base + col_i + 3) : LV_AW'(base + col_i);
                mul_a = MUL_A_W'(ew_reg[chan_reg]);
                mul_b = MUL_B_W'(ew_reg[chan_reg]);
                state_next = ST_RD == state_reg ? ST_PRED : state_reg;
            end

            // Predict, pick the context and update the neighborhood.
            ST_PRED: begin
                sym_next = diff_s[7:0];
                cx_next  = CX_W'(ctx);
                lv_we = 1'b1;
                lv_wa = LV_AW'(base + col_i);
                lv_wd = vs;
                le_we = 1'b1;
                le_wa = LV_AW'(base + col_i);
                le_wd = en;
                nw_next[chan_reg] = lv_rd;
                w_next[chan_reg]  = vs;
                ew_next[chan_reg] = en;
                state_next = ST_CUM0;
            end

            ST_CUM0: begin
                cum_ra = {cx_reg, sym_reg};
                cnt_ra = {cx_reg, sym_reg};
                tot_ra = cx_reg;
                state_next = ST_CUM1;
            end

            // Count the symbol and fetch the upper cumulative bound.
            ST_CUM1: begin
                cum_lo_next = cum_rd;
                cum_ra = (sym_reg == 8'd255) ? {cx_reg, sym_reg} : {cx_reg, sym_reg + 8'd1};
                cnt_we = 1'b1;
                cnt_wa = {cx_reg, sym_reg};
                cnt_wd = cnt_rd + 13'd1;
                tot_we = 1'b1;
                tot_wa = cx_reg;
                tot_wd = tplus;
                rb_need_next  = ((tplus & (tplus - 13'd1)) == 13'd0);
                rb_halve_next = (tplus >= TOTAL_HALVE);
                rb_extra_next = (tplus < TOTAL_FLOOR);
                rb_tot_next   = (tplus < TOTAL_FLOOR) ? tplus + TOTAL_FLOOR : tplus;
                state_next = ST_CUM2;
            end

            // Symbol span and renormalization.
            ST_CUM2: begin
                span_next = (hi_v > {1'b0, cum_lo_reg}) ? hi_v - {1'b0, cum_lo_reg}
                                                        : (PROB_BITS + 1)'(1);
                if (range_reg <= RENORM_LIMIT) begin
                    wbuf_next[wcnt_reg] = low_reg[63:32];
                    wcnt_next  = wcnt_reg + 2'd1;
                    low_next   = nl;
                    range_next = (nr > ~nl) ? ~nl : nr;
                end
                state_next = ST_LO_L;
            end

            // range * cdf in two 32-bit halves.
            ST_LO_L: begin
                mul_a = MUL_A_W'(range_reg[31:0]);
                mul_b = MUL_B_W'(cum_lo_reg);
                state_next = ST_LO_H;
            end

            ST_LO_H: begin
                mul_a = MUL_A_W'(range_reg[63:32]);
                mul_b = MUL_B_W'(cum_lo_reg);
                p0_next = mul_p_reg[47:0];
                state_next = ST_LO_S;
            end

            ST_LO_S: begin
                sum_next = {mul_p_reg[31:0], 32'd0} + {16'd0, p0_reg};
                state_next = ST_SP_L;
            end

            // Advance low, then range * span in two halves.
            ST_SP_L: begin
                low_next = low_reg + (sum_reg >> PROB_BITS);
                mul_a = MUL_A_W'(range_reg[31:0]);
                mul_b = MUL_B_W'(span_reg);
                state_next = ST_SP_H;
            end

            ST_SP_H: begin
                mul_a = MUL_A_W'(range_reg[63:32]);
                mul_b = MUL_B_W'(span_reg);
                p0_next = mul_p_reg[47:0];
                state_next = ST_SP_S;
            end

            ST_SP_S: begin
                sum_next = {mul_p_reg[31:0], 32'd0} + {16'd0, p0_reg};
                state_next = ST_FIN;
            end

            ST_FIN: begin
                range_next = (sum_reg >> PROB_BITS) - 64'd1;
                if (rb_need_reg) begin
                    dvd_next  = DIV_BASE + 33'(rb_tot_reg) - 33'd1;
                    rem_next  = '0;
                    dcnt_next = '0;
                    state_next = ST_DIV;
                end else begin
                    adv = 1'b1;
                end
            end

            // Restoring divider: one quotient bit per cycle.
            ST_DIV: begin
                if (rem_sh >= {1'b0, rb_tot_reg}) begin
                    rem_next = 13'(rem_sh - {1'b0, rb_tot_reg});
                    dvd_next = {dvd_reg[31:0], 1'b1};
                end else begin
                    rem_next = rem_sh[12:0];
                    dvd_next = {dvd_reg[31:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd32) begin
                    state_next = ST_SCALE;
                end
            end

            ST_SCALE: begin
                mul_a = MUL_A_W'(dvd_reg);
                mul_b = SCALE_MUL;
                state_next = ST_SCALE_L;
            end

            ST_SCALE_L: begin
                scale_next  = mul_p_reg[MUL_A_W-1:0];
                rb_s_next   = '0;
                acc_next    = '0;
                rb_sum_next = '0;
                state_next  = ST_RB_RD;
            end

            // Rebuild: read one count and scale the running sum.
            ST_RB_RD: begin
                cnt_ra = {cx_reg, rb_s_reg};
                mul_a  = scale_reg;
                mul_b  = MUL_B_W'(acc_reg);
                state_next = ST_RB_WR;
            end

            ST_RB_WR: begin
                cum_we = 1'b1;
                cum_wa = {cx_reg, rb_s_reg};
                cum_wd = PROB_BITS'(mul_p_reg[MUL_P_W-1:32] + 24'(rb_s_reg));
                acc_next = acc_reg + 14'(cnt_rd) + 14'(rb_extra_reg);
                if (rb_halve_reg) begin
                    cnt_we = 1'b1;
                    cnt_wa = {cx_reg, rb_s_reg};
                    cnt_wd = half;
                    rb_sum_next = rb_sum_reg + half;
                end
                if (rb_s_reg == 8'd255) begin
                    if (rb_halve_reg) begin
                        tot_we = 1'b1;
                        tot_wa = cx_reg;
                        tot_wd = rb_sum_reg + half;
                    end
                    adv = 1'b1;
                end else begin
                    rb_s_next  = rb_s_reg + 8'd1;
                    state_next = ST_RB_RD;
                end
            end

            // Hand the collected words to the output register.
            ST_EMIT: begin
                if (widx_reg == wcnt_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.code_word = wbuf_reg[widx_reg];
                    m_data_next.last_word = (widx_reg == wcnt_reg - 2'd1);
                    widx_next             = widx_reg + 2'd1;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Move to the next channel, or close the pixel and step the column.
        if (adv) begin
            if (chan_reg == 2'd2) begin
                if (col_i + 1 >= width_i) begin
                    col_next = '0;
                    for (int i = 0; i < 3; i++) begin
                        w_next[i]  = '0;
                        ew_next[i] = '0;
                        nw_next[i] = '0;
                    end
                end else begin
                    col_next = CW'(col_i + 1);
                end
                widx_next  = 2'd0;
                state_next = ST_EMIT;
            end else begin
                chan_next  = chan_reg + 2'd1;
                state_next = ST_RD;
            end
        end

        mul_p_next = mul_a * mul_b;
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            width_reg   <= 13'd1;
            chan_reg    <= 2'd0;
            col_reg     <= '0;
            low_reg     <= '0;
            range_reg   <= RANGE_INIT;
            wcnt_reg    <= 2'd0;
            widx_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                w_reg[i]  <= '0;
                ew_reg[i] <= '0;
                nw_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            width_reg   <= width_next;
            chan_reg    <= chan_next;
            col_reg     <= col_next;
            low_reg     <= low_next;
            range_reg   <= range_next;
            wcnt_reg    <= wcnt_next;
            widx_reg    <= widx_next;
            m_valid_reg <= m_valid_next;
            w_reg       <= w_next;
            ew_reg      <= ew_next;
            nw_reg      <= nw_next;
        end
        weff_reg     <= weff_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
        wbuf_reg     <= wbuf_next;
        m_data_reg   <= m_data_next;
        sym_reg      <= sym_next;
        cx_reg       <= cx_next;
        cum_lo_reg   <= cum_lo_next;
        span_reg     <= span_next;
        p0_reg       <= p0_next;
        sum_reg      <= sum_next;
        mul_p_reg    <= mul_p_next;
        rb_need_reg  <= rb_need_next;
        rb_halve_reg <= rb_halve_next;
        rb_extra_reg <= rb_extra_next;
        rb_tot_reg   <= rb_tot_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        scale_reg    <= scale_next;
        rb_s_reg     <= rb_s_next;
        acc_reg      <= acc_next;
        rb_sum_reg   <= rb_sum_next;
    end

    // Line buffer of channel values.
    always_ff @(posedge aclk) begin
        if (lv_we) begin
            lv_mem[lv_wa] <= lv_wd;
        end
        lv_rd <= lv_mem[lv_ra];
    end

    // Line buffer of error energies.
    always_ff @(posedge aclk) begin
        if (le_we) begin
            le_mem[le_wa] <= le_wd;
        end
        le_rd <= le_mem[le_ra];
    end

    // Symbol counts per context.
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd <= cnt_mem[cnt_ra];
    end

    // Cumulative frequency tables per context.
    always_ff @(posedge aclk) begin
        if (cum_we) begin
            cum_mem[cum_wa] <= cum_wd;
        end
        cum_rd <= cum_mem[cum_ra];
    end

    // Context totals.
    always_ff @(posedge aclk) begin
        if (tot_we) begin
            tot_mem[tot_wa] <= tot_wd;
        end
        tot_rd <= tot_mem[tot_ra];
    end

    // Reset always starts the clearing pass, so no beat is taken right after it.
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input taken right after reset");

    // An accepted pixel goes straight into the per-channel sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.action == ACT_PIXEL) |=> state_reg == ST_RD)
        else $error("pixel beat did not start channel coding");

    // The reciprocal of a total of at least 256 fits in 25 bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCALE) |-> dvd_reg[32:25] == 8'd0)
        else $error("divider quotient out of range");

    // At most one renormalization word per channel coded so far.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CUM2) |-> wcnt_reg <= chan_reg)
        else $error("word buffer overrun");

    // New result beats come only from the emit step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result beat raised outside emit");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the lossless RGB image encoder with a scoreboard predictor.
`timescale 1ns / 1ps

import lrie_pkg::*;

// Scoreboard: models the encoder and holds the code words it should produce.
class encoder_scoreboard;
    localparam int MW = 4096;
    localparam int NCTX = 18;
    localparam int PBITS = 12;
    localparam int ESHIFT = 3;
    localparam int CTX_ALL = 3 * NCTX;

    int          row_vals[3 * MW];
    int unsigned row_energy[3 * MW];
    int unsigned sym_cnt[CTX_ALL * 256];
    int unsigned ctx_total[CTX_ALL];
    int unsigned cum_tab[CTX_ALL * 256];
    longint unsigned coder_lo;
    longint unsigned coder_rng;
    int unsigned col;
    int          nbr[9];
    int unsigned img_width;
    out_item_t   word_q[$];
    int          errors;

    function new();
        img_width = 1;
        errors = 0;
        clear_all();
    endfunction

    // Rebuild one context's cumulative table from its counts, optionally halving them.
    function void rebuild(int unsigned cx, bit halve);
        longint unsigned total, extra, scale, acc;
        int unsigned f, sum;
        total = ctx_total[cx];
        extra = 0;
        acc = 0;
        sum = 0;
        if (total < 256) begin
            total += 256;
            extra = 1;
        end
        scale = ((64'd1 << 32) + total - 1) / total * ((64'd1 << PBITS) - 256);
        for (int s = 0; s < 256; s++) begin
            f = sym_cnt[cx * 256 + s];
            cum_tab[cx * 256 + s] = ((acc * scale) >> 32) + s;
            acc += f + extra;
            if (halve) begin
                f = f >> 1;
                sym_cnt[cx * 256 + s] = f;
                sum += f;
            end
        end
        if (halve) begin
            ctx_total[cx] = sum;
        end
    endfunction

    function void clear_all();
        foreach (row_vals[i]) row_vals[i] = 0;
        foreach (row_energy[i]) row_energy[i] = 0;
        foreach (sym_cnt[i]) sym_cnt[i] = 0;
        foreach (ctx_total[i]) ctx_total[i] = 0;
        foreach (nbr[i]) nbr[i] = 0;
        for (int k = 0; k < CTX_ALL; k++) rebuild(k, 1'b0);
        coder_lo = 0;
        coder_rng = RANGE_INIT;
        col = 0;
    endfunction

    function void push_word(logic [31:0] w);
        out_item_t r;
        r.code_word = w;
        r.last_word = 1'b0;
        word_q.push_back(r);
    endfunction

    // Range code one residual byte in a context and adapt the statistics.
    function void code_byte(int unsigned cx, int unsigned sym);
        longint unsigned c_lo, c_hi, span;
        int unsigned t;
        c_lo = cum_tab[cx * 256 + sym];
        c_hi = (sym < 255) ? cum_tab[cx * 256 + sym + 1] : (64'd1 << PBITS);
        span = (c_hi > c_lo) ? c_hi - c_lo : 1;
        if (coder_rng <= RENORM_LIMIT) begin
            push_word(coder_lo[63:32]);
            coder_lo = coder_lo << 32;
            coder_rng = (coder_rng << 32) | 64'hFFFF_FFFF;
            if (coder_rng > ~coder_lo) coder_rng = ~coder_lo;
        end
        coder_lo += (coder_rng * c_lo) >> PBITS;
        coder_rng = ((coder_rng * span) >> PBITS) - 1;
        sym_cnt[cx * 256 + sym]++;
        ctx_total[cx]++;
        t = ctx_total[cx];
        if ((t & (t - 1)) == 0) rebuild(cx, t >= 32'h1000);
    endfunction

    function void encode_pixel(in_item_t it);
        int unsigned w, x, ew, ene, cx, zz, en, lg;
        int smp[3];
        int up, west, upwest, lo, hi, guess, bias, diff;
        w = img_width;
        if (w == 0) w = 1;
        if (w > MW) w = MW;
        if (col >= w) begin
            col = 0;
            foreach (nbr[i]) nbr[i] = 0;
        end
        x = col;
        smp[0] = it.green;
        smp[1] = it.red;
        smp[2] = it.blue;
        for (int c = 0; c < 3; c++) begin
            up = row_vals[c * MW + x];
            west = nbr[c * 3];
            ew = nbr[c * 3 + 1];
            upwest = nbr[c * 3 + 2];
            ene = (x + 3 < w) ? row_energy[c * MW + x + 3] : 0;
            lo = (up < west) ? up : west;
            hi = (up < west) ? west : up;
            guess = up + west - upwest;
            bias = (c == 0) ? 0 : smp[0];
            if (guess < lo) guess = lo;
            if (guess > hi) guess = hi;
            guess += bias;
            if (guess < 0) guess = 0;
            if (guess > 255) guess = 255;
            diff = smp[c] - guess;
            // Context is the floor of log2 of the west energy squared plus one.
            lg = ew * ew + 1;
            cx = 0;
            while (lg > 1) begin
                lg = lg >> 1;
                cx++;
            end
            if (cx > NCTX - 1) cx = NCTX - 1;
            code_byte(cx + NCTX * c, diff & 8'hFF);
            zz = (diff >= 0) ? diff * 2 : (-diff) * 2 - 1;
            en = (2 * ew + (zz << ESHIFT) + ene) >> 2;
            if (en > 8191) en = 8191;
            nbr[c * 3 + 2] = up;
            row_vals[c * MW + x] = smp[c] - bias;
            row_energy[c * MW + x] = en;
            nbr[c * 3] = smp[c] - bias;
            nbr[c * 3 + 1] = en;
        end
        col = x + 1;
        if (col >= w) begin
            col = 0;
            foreach (nbr[i]) nbr[i] = 0;
        end
    endfunction

    // Note an accepted input beat and queue the words it should produce.
    function void note_input(in_item_t it);
        int n0;
        n0 = word_q.size();
        case (it.action)
            ACT_START: begin
                clear_all();
            end
            ACT_FLUSH: begin
                push_word(coder_lo[63:32]);
                push_word(coder_lo[31:0]);
                coder_lo = 0;
                coder_rng = RANGE_INIT;
            end
            ACT_PIXEL: begin
                encode_pixel(it);
            end
            default: begin
            end
        endcase
        if (word_q.size() > n0) word_q[word_q.size() - 1].last_word = 1'b1;
    endfunction

    // Compare a result beat against the oldest expected word.
    function void check_result(out_item_t got);
        out_item_t exp_w;
        if (word_q.size() == 0) begin
            $error("unexpected result beat: code_word %h", got.code_word);
            errors++;
            return;
        end
        exp_w = word_q.pop_front();
        if (got.code_word !== exp_w.code_word) begin
            $error("code_word: expected %h, got %h", exp_w.code_word, got.code_word);
            errors++;
        end
        if (got.last_word !== exp_w.last_word) begin
            $error("last_word: expected %b, got %b", exp_w.last_word, got.last_word);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int LIMIT = 3000000;
    localparam int SETTLE = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [12:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    encoder_scoreboard sb;
    int  cycles = 0;
    int  burst_left = 0;
    int  sent = 0;
    bit  hold_off = 1'b0;
    int  prev_g = 128, prev_r = 128, prev_b = 128;

    lossless_rgb_image_encoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // Cycle limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("lossless_rgb_image_encoder: mismatch");
            $finish;
        end
    end

    // Check every accepted result beat.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Receiver stall pattern, cycling through four ready styles.
    always @(negedge aclk) begin
        case ((cycles / 64) % 4)
            0: m_ready <= !hold_off;
            1: m_ready <= !hold_off && ($urandom_range(1, 0) == 1);
            2: m_ready <= !hold_off && ($urandom_range(3, 0) == 0);
            default: m_ready <= !hold_off && ($urandom_range(7, 0) != 0);
        endcase
    end

    // Long receiver hold-off in the middle of a random phase, so the encoder fills up
    // and stalls its input while the sender keeps offering beats.
    initial begin
        wait (sent >= 150);
        hold_off = 1'b1;
        repeat (4000) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Offer one beat, with bursty sender gaps, and wait for its acceptance.
    task automatic send_beat(in_item_t it);
        @(negedge aclk);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(20, 1)) @(negedge aclk);
            burst_left = $urandom_range(30, 1);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        sent++;
    endtask

    // Drop the input valid after the last beat of a sequence.
    task automatic input_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic send_code(logic [1:0] act, int r, int g, int b);
        in_item_t it;
        it.action = act;
        it.red = r[7:0];
        it.green = g[7:0];
        it.blue = b[7:0];
        send_beat(it);
    endtask

    // Wait until every expected word has arrived and the block has settled.
    task automatic drain();
        input_idle();
        while (sb.word_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_width(int w);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w[12:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.img_width = w[12:0];
    endtask

    // Mostly smooth pixels with occasional jumps, plus flushes, starts and unused codes.
    task automatic random_phase(int count);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99, 0);
            if (sel < 5) begin
                send_code(ACT_FLUSH, $urandom, $urandom, $urandom);
            end else if (sel < 6) begin
                send_code(ACT_START, $urandom, $urandom, $urandom);
            end else if (sel < 8) begin
                send_code(2'd3, $urandom, $urandom, $urandom);
            end else if (sel < 30) begin
                send_code(ACT_PIXEL, $urandom, $urandom, $urandom);
            end else begin
                prev_g = (prev_g + $urandom_range(8, 0) - 4) & 8'hFF;
                prev_r = (prev_g + $urandom_range(6, 0) - 3) & 8'hFF;
                prev_b = (prev_g + $urandom_range(6, 0) - 3) & 8'hFF;
                send_code(ACT_PIXEL, prev_r, prev_g, prev_b);
            end
        end
        send_code(ACT_FLUSH, 0, 0, 0);
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: sample extremes, every action, the unused code, row edges.
        write_width(3);
        send_code(ACT_PIXEL, 0, 0, 0);
        send_code(ACT_PIXEL, 255, 255, 255);
        send_code(ACT_PIXEL, 255, 0, 255);
        send_code(ACT_PIXEL, 0, 255, 0);
        send_code(2'd3, 255, 255, 255);
        send_code(ACT_PIXEL, 128, 127, 1);
        send_code(ACT_FLUSH, 0, 0, 0);
        send_code(ACT_FLUSH, 255, 255, 255);
        send_code(ACT_PIXEL, 170, 85, 170);
        send_code(ACT_PIXEL, 85, 170, 85);
        send_code(ACT_PIXEL, 1, 254, 2);
        send_code(ACT_START, 0, 0, 0);
        send_code(ACT_PIXEL, 200, 10, 30);
        send_code(ACT_PIXEL, 10, 200, 250);
        send_code(ACT_FLUSH, 0, 0, 0);
        drain();

        // Random phases at several widths, the extremes among them.
        write_width(1);
        random_phase(45);
        drain();
        write_width(4096);
        random_phase(60);
        drain();
        write_width(3);
        random_phase(45);
        drain();
        write_width(0);
        random_phase(30);
        drain();
        write_width(8191);
        random_phase(30);
        drain();
        write_width(5);
        random_phase(90);
        input_idle();
        while (sb.word_q.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);

        if (sb.errors == 0 && sb.word_q.size() == 0) begin
            $display("lossless_rgb_image_encoder: match");
        end else begin
            $display("lossless_rgb_image_encoder: mismatch");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/lrie_pkg.sv
sv/lossless_rgb_image_encoder.sv
verif/tb_top.sv
